// ===== hw/rtl/lz78_pkg.sv =====
`default_nettype none
package lz78_pkg;

    // pairs counter saturates here
    localparam logic [12:0] COUNT_MAX     = 13'h1FFF;
    localparam logic [12:0] BYTE_CODE_MAX = 13'd255;
    localparam logic [1:0]  CODE_ONE_BYTE = 2'd1;
    localparam logic [1:0]  CODE_TWO_BYTE = 2'd2;
    localparam logic [12:0] LIMIT_RESET   = 13'd4096;

    // one queued input word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_item;

    // queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_head;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_CHECK
    } t_state;

endpackage
`default_nettype wire

// ===== hw/rtl/lz78_if.sv =====
`default_nettype none
interface lz78_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface lz78_out_if;
    logic        valid;
    logic        ready;
    logic [12:0] prefix_code;
    logic [7:0]  symbol;
    logic [12:0] entry_number;
    logic [1:0]  code_bytes;
    logic        end_of_stream;
    modport source (output valid, output prefix_code, output symbol, output entry_number,
                    output code_bytes, output end_of_stream, input ready);
    modport sink (input valid, input prefix_code, input symbol, input entry_number,
                  input code_bytes, input end_of_stream, output ready);
endinterface

interface lz78_cfg_if;
    logic        valid;
    logic        ready;
    logic [12:0] dictionary_limit;
    modport source (output valid, output dictionary_limit, input ready);
    modport sink (input valid, input dictionary_limit, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lz78_front.sv =====
`default_nettype none
module lz78_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    lz78_in_if.sink               i_in,
    output lz78_pkg::t_queue_head o_head,
    input  wire                   i_pop
);
    import lz78_pkg::*;

    t_item      r_buf [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    // two-word queue between input and back end
    assign i_in.ready   = (r_cnt != 2'd2);
    assign w_push       = i_in.valid && i_in.ready;
    assign w_pop        = i_pop && (r_cnt != 2'd0);
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wp] <= '{data_byte: i_in.data_byte, last_byte: i_in.last_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/lz78_back.sv =====
`default_nettype none
module lz78_back #(
    parameter int DICT_ENTRIES = 4096
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire lz78_pkg::t_queue_head i_head,
    output logic                       o_pop,
    input  wire [12:0]                 i_limit,
    lz78_out_if.source                 o_out
);
    import lz78_pkg::*;

    localparam int CW = $clog2(DICT_ENTRIES + 1);
    localparam int HB = $clog2(DICT_ENTRIES) + 1;
    localparam int KW = CW + 8;
    localparam int SW = KW + CW;
    localparam int HD = 2 ** HB;

    // hash slots: {prefix code, byte, entry code}, code 0 marks empty
    logic [SW-1:0] r_mem [HD];
    logic [SW-1:0] r_rd;

    t_state        r_state, n_state;
    logic [HB-1:0] r_addr, n_addr;
    logic [CW-1:0] r_cur, n_cur;
    logic [CW-1:0] r_used, n_used;
    logic [12:0]   r_pairs, n_pairs;
    logic          r_ov;
    logic [12:0]   r_prefix;
    logic [7:0]    r_sym;
    logic [12:0]   r_num;
    logic [1:0]    r_cbytes;
    logic          r_eos;

    logic          w_emit;
    logic          w_we;
    logic [SW-1:0] w_wdata;
    logic [KW-1:0] w_key;
    logic [KW-1:0] w_fold;
    logic [HB-1:0] w_hash;
    logic [CW-1:0] w_slot_code;
    logic [KW-1:0] w_slot_key;
    logic          w_empty;
    logic          w_hit;
    logic          w_out_free;
    logic          w_grow;
    logic [31:0]   w_limit_eff;
    logic [31:0]   w_cur_wide;

    // lookup key and folded hash
    assign w_key       = {r_cur, i_head.item.data_byte};
    assign w_fold      = w_key >> HB;
    assign w_hash      = w_key[HB-1:0] ^ w_fold[HB-1:0];
    assign w_slot_code = r_rd[CW-1:0];
    assign w_slot_key  = r_rd[SW-1:CW];
    assign w_empty     = (w_slot_code == '0);
    assign w_hit       = !w_empty && (w_slot_key == w_key);
    assign w_out_free  = !r_ov || o_out.ready;
    assign w_cur_wide  = 32'(r_cur);

    // limit clamped to table size
    assign w_limit_eff = (32'(i_limit) > 32'(DICT_ENTRIES)) ? 32'(DICT_ENTRIES)
                                                            : 32'(i_limit);
    assign w_grow      = (32'(r_used) < w_limit_eff);

    // slot memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_addr] <= w_wdata;
        end
        r_rd <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_addr  <= '0;
            r_cur   <= '0;
            r_used  <= '0;
            r_pairs <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_cur   <= n_cur;
            r_used  <= n_used;
            r_pairs <= n_pairs;
            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_prefix <= w_cur_wide[12:0];
            r_sym    <= i_head.item.data_byte;
            r_num    <= n_pairs;
            r_cbytes <= (n_pairs <= BYTE_CODE_MAX) ? CODE_ONE_BYTE : CODE_TWO_BYTE;
            r_eos    <= i_head.item.last_byte;
        end
    end

    // probe sequencer
    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        n_cur   = r_cur;
        n_used  = r_used;
        n_pairs = r_pairs;
        w_emit  = 1'b0;
        w_we    = 1'b0;
        w_wdata = {w_key, r_used + CW'(1)};
        o_pop   = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_wdata = '0;
                n_addr  = r_addr + HB'(1);
                if (r_addr == HB'(HD - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_head.valid) begin
                    n_addr  = w_hash;
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (w_hit && !i_head.item.last_byte) begin
                    n_cur   = w_slot_code;
                    o_pop   = 1'b1;
                    n_state = ST_IDLE;
                end else if (w_empty || w_hit) begin
                    if (w_out_free) begin
                        w_emit  = 1'b1;
                        n_pairs = (r_pairs < COUNT_MAX) ? r_pairs + 13'd1 : r_pairs;
                        if (w_empty && w_grow) begin
                            w_we   = 1'b1;
                            n_used = r_used + CW'(1);
                        end
                        n_cur   = '0;
                        o_pop   = 1'b1;
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_addr  = r_addr + HB'(1);
                    n_state = ST_LOOK;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out.valid         = r_ov;
    assign o_out.prefix_code   = r_prefix;
    assign o_out.symbol        = r_sym;
    assign o_out.entry_number  = r_num;
    assign o_out.code_bytes    = r_cbytes;
    assign o_out.end_of_stream = r_eos;

endmodule
`default_nettype wire

// ===== hw/rtl/lz78_encoder.sv =====
// an accepted byte goes through the two-word input queue, then a slot read and compare
// per hash probe, with one more read and compare for each collision; a byte is looked
// up only after the previous byte is done, and a pair waits while the output word is full
// reset: synchronous active low; after reset a clearing pass writes every one of the
// 2 * 2**clog2(DICT_ENTRIES) hash slots (8192 at the default) before the first lookup
`default_nettype none
module lz78_encoder #(
    parameter int DICT_ENTRIES = 4096
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    lz78_in_if.sink     i_in,
    lz78_cfg_if.sink    i_cfg,
    lz78_out_if.source  o_out
);
    import lz78_pkg::*;

    t_queue_head w_head;
    logic        w_pop;
    logic [12:0] r_limit;

    // dictionary limit register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg.valid) begin
            r_limit <= i_cfg.dictionary_limit;
        end
    end

    lz78_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    lz78_back #(
        .DICT_ENTRIES (DICT_ENTRIES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .i_limit (r_limit),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
module testbench;
    import lz78_pkg::*;

    localparam int DICT_ENTRIES = 4096;
    localparam int CYCLE_LIMIT  = 2000000;

    logic i_clk;
    logic i_rst_n;
    int   cycle_count;
    int   error_count;

    lz78_in_if  in_ch();
    lz78_cfg_if cfg_ch();
    lz78_out_if out_ch();

    lz78_encoder #(.DICT_ENTRIES(DICT_ENTRIES)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .i_cfg   (cfg_ch.sink),
        .o_out   (out_ch.source)
    );

    // one expected pair word
    typedef struct packed {
        logic [12:0] prefix_code;
        logic [7:0]  symbol;
        logic [12:0] entry_number;
        logic [1:0]  code_bytes;
        logic        end_of_stream;
    } t_pair;

    task automatic report_mismatch(input string what);
        $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // dictionary predictor plus queue of pending pairs
    class pair_scoreboard;
        logic [20:0] phrases [DICT_ENTRIES];
        int          phrase_count;
        int          pair_count;
        int          match_code;
        int          match_prefix;
        int          limit;
        t_pair       pending [$];

        function new();
            phrase_count = 0;
            pair_count   = 0;
            match_code   = 0;
            match_prefix = 0;
            limit        = LIMIT_RESET;
        endfunction

        function void set_limit(input logic [12:0] value);
            limit = value;
        endfunction

        function void push_pair(input int prefix, input logic [7:0] sym, input logic eos);
            t_pair p;
            if (pair_count < COUNT_MAX) pair_count++;
            p.prefix_code   = prefix[12:0];
            p.symbol        = sym;
            p.entry_number  = pair_count[12:0];
            p.code_bytes    = (pair_count <= BYTE_CODE_MAX) ? CODE_ONE_BYTE : CODE_TWO_BYTE;
            p.end_of_stream = eos;
            pending.push_back(p);
        endfunction

        // note an accepted byte
        function void note_byte(input logic [7:0] sym, input logic last);
            int found;
            int lim;
            logic [20:0] key;
            found = 0;
            key = {match_code[12:0], sym};
            for (int k = 0; k < phrase_count; k++) begin
                if (phrases[k] == key) begin
                    found = k + 1;
                    break;
                end
            end
            lim = (limit > DICT_ENTRIES) ? DICT_ENTRIES : limit;
            if (found != 0) begin
                match_prefix = match_code;
                match_code   = found;
                if (last) begin
                    push_pair(match_prefix, sym, 1'b1);
                    match_code   = 0;
                    match_prefix = 0;
                end
            end else begin
                push_pair(match_code, sym, last);
                if (phrase_count < lim) begin
                    phrases[phrase_count] = key;
                    phrase_count++;
                end
                match_code   = 0;
                match_prefix = 0;
            end
        endfunction

        // compare a delivered pair with the oldest expectation
        task check_pair(input t_pair got);
            t_pair want;
            if (pending.size() == 0) begin
                report_mismatch("pair word with nothing expected");
                return;
            end
            want = pending.pop_front();
            if (got.prefix_code !== want.prefix_code)
                report_mismatch($sformatf("prefix_code %0d want %0d",
                                got.prefix_code, want.prefix_code));
            if (got.symbol !== want.symbol)
                report_mismatch($sformatf("symbol %0d want %0d", got.symbol, want.symbol));
            if (got.entry_number !== want.entry_number)
                report_mismatch($sformatf("entry_number %0d want %0d",
                                got.entry_number, want.entry_number));
            if (got.code_bytes !== want.code_bytes)
                report_mismatch($sformatf("code_bytes %0d want %0d",
                                got.code_bytes, want.code_bytes));
            if (got.end_of_stream !== want.end_of_stream)
                report_mismatch($sformatf("end_of_stream %0d want %0d",
                                got.end_of_stream, want.end_of_stream));
        endtask
    endclass

    pair_scoreboard board;
    bit quiet_phase;
    bit hold_sink;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // sink side: random stalls, plus a long hold when asked
    initial begin
        t_pair got;
        int    gap;
        out_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!quiet_phase && !hold_sink && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                gap = $urandom_range(1, 4);
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= !hold_sink;
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                got = {out_ch.prefix_code, out_ch.symbol, out_ch.entry_number,
                       out_ch.code_bytes, out_ch.end_of_stream};
                board.check_pair(got);
            end
        end
    end

    task automatic send_byte(input logic [7:0] sym, input logic last);
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= sym;
        in_ch.last_byte <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        board.note_byte(sym, last);
    endtask

    task automatic end_send();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait until every pair is in, then let the pipeline drain
    task automatic drain();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [12:0] value);
        cfg_ch.valid            <= 1'b1;
        cfg_ch.dictionary_limit <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        board.set_limit(value);
        @(posedge i_clk);
    endtask

    // mostly repetitive text from a small alphabet so phrases grow long
    task automatic send_text(input int count, input int alphabet, input bit end_it);
        logic [7:0] sym;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) == 0) sym = 8'($urandom_range(0, 255));
            else sym = 8'(32'h41 + $urandom_range(0, alphabet - 1));
            send_byte(sym, end_it && (n == count - 1));
        end
    endtask

    initial begin
        cycle_count  = 0;
        error_count  = 0;
        quiet_phase  = 1'b0;
        hold_sink    = 1'b0;
        board        = new();
        i_rst_n      = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        in_ch.last_byte = 1'b0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.dictionary_limit = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, match ending on final byte, miss on final byte
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        end_send();
        drain();

        // dictionary limit cut to a single entry, below use, then lowered to zero
        write_limit(13'd1);
        for (int n = 0; n < 8; n++) send_byte(8'h41 + 8'(n[1:0]), n == 7);
        end_send();
        drain();
        write_limit(13'd0);
        send_text(10, 2, 1'b1);
        end_send();
        drain();

        // limit above table size, the largest code
        write_limit(13'h1FFF);
        send_text(150, 3, 1'b0);

        // long sink hold while bytes keep coming
        hold_sink = 1'b1;
        fork
            send_text(40, 3, 1'b0);
            begin
                repeat (300) @(posedge i_clk);
                hold_sink = 1'b0;
            end
        join
        end_send();
        drain();

        write_limit(13'd20);
        send_text(150, 4, 1'b1);
        end_send();
        drain();

        write_limit(LIMIT_RESET);
        send_text(150, 8, 1'b0);
        quiet_phase = 1'b1;
        send_text(110, 2, 1'b1);
        end_send();
        drain();

        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
